// ----- hdl/bpa_pkg.sv -----
// Shared types and codes for the bit-packed unsigned array core.
package bpa_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Configuration register indexes
    localparam logic REG_BITS  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam int unsigned VAL_W = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_MOD,
        S_LOAD,
        S_RADDR,
        S_RDATA,
        S_EVAL,
        S_MID
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       start;
        logic       bs_init;
        logic       mul;
        logic       mod_en;
        logic       load_addr;
        logic       cap;
        logic       bs_upd;
        logic       bs_mid;
        logic       fin;
        logic [3:0] k;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       is_rw;
        logic       is_search;
        logic       rerr;
        logic       len_zero;
        logic       eq;
        logic       lr;
        logic       out_free;
        logic [3:0] nb;
    } t_stat;

endpackage

// ----- hdl/bpa_ctrl.sv -----
// Sequencer for decode, address reduction, byte walk and search steps.
module bpa_ctrl #(
    parameter int unsigned NS  = 2,
    parameter int unsigned SCW = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  bpa_pkg::t_stat   i_stat,
    output bpa_pkg::t_cmd    o_cmd,
    output logic [SCW-1:0]   o_step,
    output logic             o_idle
);
    import bpa_pkg::*;

    t_state         r_state, n_state;
    logic [SCW-1:0] r_step, n_step;
    logic [3:0]     r_k, n_k;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.k = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_stat.is_rw && i_stat.rerr) || (!i_stat.is_rw && !i_stat.is_search)
                    || (i_stat.is_search && i_stat.len_zero)) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    o_cmd.bs_init = i_stat.is_search;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = SCW'(NS - 1);
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_en = 1'b1;
                n_step       = r_step - 1'b1;
                if (r_step == '0) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_addr = 1'b1;
                n_k             = '0;
                n_state         = S_RADDR;
            end
            S_RADDR: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.cap = 1'b1;
                n_k       = r_k + 1'b1;
                n_state   = (r_k + 1'b1 == i_stat.nb) ? S_EVAL : S_RADDR;
            end
            S_EVAL: begin
                if (i_stat.is_search && !i_stat.eq && i_stat.lr) begin
                    o_cmd.bs_upd = 1'b1;
                    n_state      = S_MID;
                end else if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_MID: begin
                o_cmd.bs_mid = 1'b1;
                n_state      = S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_step = r_step;
    assign o_idle = (r_state == S_IDLE);

endmodule

// ----- hdl/bpa_dp.sv -----
// Datapath: configuration, byte store, index multiply, address reduction, search bounds.
module bpa_dp #(
    parameter int unsigned STORE_BYTES = 4096,
    parameter int unsigned MAX_ENTRIES = 32768,
    parameter int unsigned SCW         = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpa_pkg::t_cmd               i_cmd,
    input  logic [SCW-1:0]              i_step,
    output bpa_pkg::t_stat              o_stat,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [15:0]                 i_cfg_data,
    input  logic [1:0]                  i_opcode,
    input  logic [94:0]                 i_in_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [79:0]                 o_out_data,
    output logic [1:0]                  o_out_user
);
    import bpa_pkg::*;

    localparam int unsigned AW  = $clog2(STORE_BYTES);
    localparam int unsigned IW  = $clog2(MAX_ENTRIES) + 1;
    localparam int unsigned PW  = IW + 7;
    localparam int unsigned BAW = PW - 3;
    localparam int unsigned EW  = BAW + AW + 1;
    // Scaled reciprocal of the store size; the quotient estimate is exact or one low
    localparam logic [BAW-1:0] RECIP = BAW'((64'd1 << BAW) / 64'(STORE_BYTES));

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    logic [6:0]  r_bpe;
    logic [15:0] r_count;
    logic [1:0]  r_op;
    logic [14:0] r_pos;
    logic [63:0] r_val;
    logic [IW-1:0] r_len;
    logic        r_rerr;
    logic signed [IW:0] r_left, r_right, r_mid;
    logic [BAW-1:0] r_rem;
    logic [BAW-1:0] r_q;
    logic [2:0]  r_sh;
    logic [AW-1:0] r_addr;
    logic [71:0] r_acc;
    logic        r_ovalid;
    logic [79:0] r_odata;
    logic [1:0]  r_ouser;

    logic [6:0]  w;
    logic [63:0] mask;
    logic [IW-1:0] idx;
    logic [PW-1:0] prod;
    logic [2*BAW-1:0] qprod;
    logic [63:0] tk;
    logic [71:0] sv, m72;
    logic [7:0]  mb, merged;
    logic [IW-1:0] len_in;
    logic signed [IW:0] diff;
    logic        is_rw, is_search, found;

    // Effective width and mask
    always_comb begin
        if (r_bpe == 7'd0) w = 7'd1;
        else if (r_bpe > 7'd64) w = 7'd64;
        else w = r_bpe;
        mask = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    end

    assign is_rw     = (r_op == OP_READ) || (r_op == OP_WRITE);
    assign is_search = (r_op == OP_SEARCH);
    assign idx       = is_search ? r_mid[IW-1:0] : IW'(r_pos);
    assign prod      = PW'(idx) * PW'(w);
    assign qprod     = (2*BAW)'(r_rem) * (2*BAW)'(RECIP);
    assign tk        = 64'(r_acc >> r_sh) & mask;
    assign sv        = {8'd0, r_val & mask} << r_sh;
    assign m72       = {8'd0, mask} << r_sh;
    assign mb        = m72[{i_cmd.k, 3'b000} +: 8];
    assign merged    = (r_rdata & ~mb) | (sv[{i_cmd.k, 3'b000} +: 8] & mb);
    assign len_in    = (32'(i_in_data[94:79]) > MAX_ENTRIES) ? IW'(MAX_ENTRIES)
                                                            : IW'(i_in_data[94:79]);
    assign diff      = r_right - r_left;
    assign found     = is_search && (r_len != '0) && (tk == r_val);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpe   <= 7'd1;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BITS:  r_bpe   <= i_cfg_data[6:0];
                REG_COUNT: r_count <= i_cfg_data;
                default:   r_count <= r_count;
            endcase
        end
    end

    // Byte store: registered read, write of each merged byte
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_addr];
        if (i_cmd.cap && (r_op == OP_WRITE)) r_mem[r_addr] <= merged;
    end

    // Item registers and probe datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_opcode;
            r_pos  <= i_in_data[14:0];
            r_val  <= i_in_data[78:15];
            r_len  <= len_in;
            r_rerr <= ({1'b0, i_in_data[14:0]} >= r_count);
        end
        if (i_cmd.bs_init) begin
            r_left  <= '0;
            r_right <= $signed({1'b0, r_len}) - (IW+1)'(1);
            r_mid   <= $signed({1'b0, r_len - 1'b1}) >>> 1;
        end
        if (i_cmd.bs_upd) begin
            if (tk < r_val) r_left  <= r_mid + (IW+1)'(1);
            else            r_right <= r_mid - (IW+1)'(1);
        end
        if (i_cmd.bs_mid) r_mid <= r_left + ((diff >= 0) ? (diff >>> 1) : '0);
        if (i_cmd.mul) begin
            r_rem <= prod[PW-1:3];
            r_sh  <= prod[2:0];
        end
        // Reduce byte address modulo store size: quotient estimate, then subtract
        if (i_cmd.mod_en) begin
            if (i_step != '0) r_q <= qprod[2*BAW-1:BAW];
            else r_rem <= BAW'(EW'(r_rem) - EW'(r_q) * EW'(STORE_BYTES));
        end
        // Load the start address, taking off one more store size if needed
        if (i_cmd.load_addr) begin
            r_addr <= (EW'(r_rem) >= EW'(STORE_BYTES)) ?
                      AW'(EW'(r_rem) - EW'(STORE_BYTES)) : AW'(r_rem);
        end
        if (i_cmd.cap) begin
            r_acc[{i_cmd.k, 3'b000} +: 8] <= r_rdata;
            r_addr <= (32'(r_addr) == STORE_BYTES - 1) ? '0 : r_addr + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_odata[63:0]  <= (!is_rw || r_rerr) ? 64'd0 :
                              (r_op == OP_READ) ? tk : (r_val & mask);
            r_odata[78:64] <= found ? 15'($unsigned(r_mid)) : 15'd0;
            r_odata[79]    <= 1'b0;
            r_ouser        <= {is_rw && r_rerr, found};
        end
    end

    // Status to controller
    always_comb begin
        o_stat.is_rw     = is_rw;
        o_stat.is_search = is_search;
        o_stat.rerr      = r_rerr;
        o_stat.len_zero  = (r_len == '0);
        o_stat.eq        = (tk == r_val);
        o_stat.lr        = (r_left < r_right);
        o_stat.out_free  = !r_ovalid || i_ready;
        o_stat.nb        = 4'((8'(r_sh) + 8'(w) + 8'd7) >> 3);
    end

    assign o_valid    = r_ovalid;
    assign o_out_data = r_odata;
    assign o_out_user = r_ouser;

endmodule

// ----- hdl/bit_packed_uint_array_core.sv -----
// Top level of the bit-packed unsigned array core.
// Unsigned numbers of 1 to 64 bits (register 0, clamped) are packed LSB first into a
// single-port byte store of STORE_BYTES bytes; register 1 bounds reads and writes.
// One item is handled at a time: after an accept and a decode step, every entry access
// runs a multiply step, the address reduction (a reciprocal multiply for the quotient,
// then a subtract), a load step that applies the last correction, then, as the store
// has a single port and a registered read, an address step and a data step for each
// byte the entry spans (up to nine), then an evaluation step. A search repeats the
// multiply-to-evaluation part per probe (about log2 of its length probes, with a step
// to set each next midpoint). Range errors, opcode 3 and empty searches finish from
// the decode step once the output register is free. A result waits in an output
// register, so the next item is taken while it waits. The store is not cleared: read
// only what was written.
module bit_packed_uint_array_core #(
    parameter int unsigned STORE_BYTES = 4096,
    parameter int unsigned MAX_ENTRIES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // position[14:0], operand_value[78:15], search_length[94:79], zero pad
    input  logic [95:0] i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result_value[63:0], found_index[78:64], zero pad
    output logic [79:0] o_m_tdata,
    // found[0], range_error[1]
    output logic [1:0]  o_m_tuser
);
    import bpa_pkg::*;

    localparam int unsigned NS  = 2;
    localparam int unsigned SCW = $clog2(NS + 1);

    t_cmd           cmd;
    t_stat          stat;
    logic [SCW-1:0] step;
    logic           idle;
    logic           s_accept;

    assign s_accept   = i_s_tvalid && idle;
    assign o_s_tready = idle;

    bpa_ctrl #(
        .NS  (NS),
        .SCW (SCW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_step   (step),
        .o_idle   (idle)
    );

    bpa_dp #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES),
        .SCW         (SCW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_step     (step),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_s_tuser),
        .i_in_data  (i_s_tdata[94:0]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_out_data (o_m_tdata),
        .o_out_user (o_m_tuser)
    );

    // Busy right after an accepted transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input ready right after a transfer");

    // A hit and a range error never come together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("found and range error both set");

    // Index is zero unless found
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[78:64] == 15'd0))
        else $error("found index set without a hit");

endmodule
